[hw/rtl/odf_pkg.sv]
package odf_pkg;

  // full frame length in bytes, and the bytes held between beats
  localparam int FRAME_LEN = 20;
  localparam int WIN_DEPTH = FRAME_LEN - 1;
  localparam int CNT_W     = $clog2(FRAME_LEN);

  localparam int BYTE_W     = 8;
  localparam int CFG_ADDR_W = 2;
  localparam int RES_W      = 96;

  // configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_SYNC = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_TYPE = 2'd1;

  localparam logic [BYTE_W-1:0] SYNC_RST = 8'hCC;
  localparam logic [BYTE_W-1:0] TYPE_RST = 8'd14;

  // frame offsets of the checked bytes
  localparam int OFS_SYNC = 0;
  localparam int OFS_TYPE = 4;

  // one decoded frame, lowest field in the lowest bits
  typedef struct packed {
    logic signed [31:0] right_position;
    logic signed [31:0] left_position;
    logic signed [15:0] linear_speed;
    logic signed [15:0] angular_rate;
  } odf_result_t;

  // result handed from the window to the output buffer
  typedef struct packed {
    logic        hit;
    odf_result_t data;
  } odf_push_t;

endpackage

[hw/rtl/odf_window.sv]
module odf_window
  import odf_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_fire,
  input  logic [BYTE_W-1:0] in_byte,
  input  logic [BYTE_W-1:0] sync_value,
  input  logic [BYTE_W-1:0] type_value,
  output odf_push_t         push
);

  // last bytes received, oldest at entry 0
  logic [BYTE_W-1:0] win_r [WIN_DEPTH];
  logic [CNT_W-1:0]  cnt_r;
  logic [CNT_W-1:0]  cnt_nxt;
  logic              full;
  logic              match;

  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(WIN_DEPTH);

  assign full  = (cnt_r == CNT_FULL);
  assign match = (win_r[OFS_SYNC] == sync_value) && (win_r[OFS_TYPE] == type_value);

  // the incoming beat is frame byte 19, which is never used
  always_comb begin
    push.hit                 = in_fire && full && match;
    push.data.angular_rate   = {win_r[5], win_r[6]};
    push.data.linear_speed   = {win_r[7], win_r[8]};
    push.data.left_position  = {win_r[11], win_r[12], win_r[13], win_r[14]};
    push.data.right_position = {win_r[15], win_r[16], win_r[17], win_r[18]};
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (in_fire) begin
      if (full) begin
        cnt_nxt = match ? '0 : CNT_FULL;
      end else begin
        cnt_nxt = cnt_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // shift on every beat; the count says how many entries belong to the frame
  always_ff @(posedge clk) begin
    if (in_fire) begin
      for (int i = 0; i < WIN_DEPTH - 1; i++) begin
        win_r[i] <= win_r[i+1];
      end
      win_r[WIN_DEPTH-1] <= in_byte;
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_FULL)
    else $error("window count out of range");

  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && !full |=> cnt_r == $past(cnt_r) + CNT_W'(1))
    else $error("window count did not advance");

endmodule

[hw/rtl/odf_out_buf.sv]
module odf_out_buf
  import odf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  odf_push_t   push,
  output logic        can_push,
  output logic        out_valid,
  input  logic        out_ready,
  output odf_result_t out_data
);

  logic        out_valid_r;
  logic        out_valid_nxt;
  odf_result_t out_data_r;
  odf_result_t out_data_nxt;
  logic        skid_valid_r;
  logic        skid_valid_nxt;
  odf_result_t skid_data_r;
  odf_result_t skid_data_nxt;
  logic        pop;

  assign pop       = out_valid_r && out_ready;
  assign can_push  = !skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (!out_valid_r || pop) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end else if (push.hit) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = push.data;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end else if (push.hit) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = push.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held with empty output register");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    push.hit |-> !skid_valid_r)
    else $error("result pushed into full buffer");

endmodule

[hw/rtl/odometry_frame_deframer.sv]
// the beat carrying frame byte 19 registers its result into the output or skid register
// one byte per cycle while in_tready is high; the window's byte compares are combinational
// the two-entry output buffer keeps in_tready high until two results wait for out_tready
// reset (rst_n low, synchronous): window empty, output buffer empty,
// sync_value 0xCC, type_value 14; window bytes themselves are not cleared
module odometry_frame_deframer
  import odf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // received byte stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // [7:0] rx_byte
  // decoded frames
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [RES_W-1:0]      out_tdata,  // [15:0] angular_rate, [31:16] linear_speed,
                                            // [63:32] left_position, [95:64] right_position
  // register writes
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [7:0]            cfg_wdata
);

  logic [BYTE_W-1:0] sync_r;
  logic [BYTE_W-1:0] type_r;
  logic              in_fire;
  logic              can_push;
  odf_push_t         push;
  odf_result_t       out_data;

  // a beat is only taken while the buffer has room for the result it may cause
  assign in_tready = can_push;
  assign in_fire   = in_tvalid && in_tready;

  // config registers, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_r <= SYNC_RST;
      type_r <= TYPE_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_SYNC: sync_r <= cfg_wdata;
        CFG_TYPE: type_r <= cfg_wdata;
        default:  ;
      endcase
    end
  end

  // byte window and frame check
  odf_window u_window (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_fire    (in_fire),
    .in_byte    (in_tdata),
    .sync_value (sync_r),
    .type_value (type_r),
    .push       (push)
  );

  // result register plus skid entry
  odf_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .can_push  (can_push),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_data)
  );

  assign out_tdata = out_data;

endmodule
